// ----- hw/rtl/rwgf_pkg.sv -----
// rwgf_pkg: shared types, codes and defaults for the reader/writer gated fifo
// depends on nothing; used by rwgf_ctrl, rwgf_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package rwgf_pkg;

  // default number of fifo entries
  localparam int unsigned DefaultDepth = 4;

  // operation codes
  localparam logic [1:0] OpReadStart  = 2'd0;
  localparam logic [1:0] OpReadStop   = 2'd1;
  localparam logic [1:0] OpWriteStart = 2'd2;
  localparam logic [1:0] OpWriteStop  = 2'd3;

  // status codes
  localparam logic [3:0] StReadOk        = 4'd0;
  localparam logic [3:0] StEmpty         = 4'd1;
  localparam logic [3:0] StWriterActive  = 4'd2;
  localparam logic [3:0] StNoReader      = 4'd3;
  localparam logic [3:0] StReadStopped   = 4'd4;
  localparam logic [3:0] StWriteOk       = 4'd5;
  localparam logic [3:0] StFull          = 4'd6;
  localparam logic [3:0] StReadersActive = 4'd7;
  localparam logic [3:0] StWriteStopped  = 4'd8;
  localparam logic [3:0] StNoWriter      = 4'd9;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] write_byte;
  } in_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] read_byte;
    logic [2:0] readers_now;
  } out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;        // latch the status code of this transaction
    logic       pop;
    logic       push;
    logic       reader_inc;
    logic       reader_dec;
    logic       writer_set;
    logic       writer_clr;
    logic [3:0] code;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic writer_holds;
    logic empty;
    logic full;
    logic no_readers;
    logic readers_max;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rwgf_datapath.sv -----
// rwgf_datapath: fifo storage, pointers, reader count, writer flag, result regs
// depends on rwgf_pkg; driven by commands from rwgf_ctrl
`timescale 1ns / 1ps
`default_nettype none

module rwgf_datapath #(
  parameter int unsigned DEPTH = rwgf_pkg::DefaultDepth
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  rwgf_pkg::cmd_t       cmd_i,
  input  wire  [7:0]           write_byte_i,
  output rwgf_pkg::dp_status_t status_o,
  output rwgf_pkg::out_t       result_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] reader_q, reader_d;
  logic          writer_q, writer_d;
  logic [3:0]    code_q;
  logic [SW-1:0] wsum;
  logic [AW-1:0] waddr;

  // tail index, wrapped without a modulo
  always_comb begin
    wsum = SW'(head_q) + SW'(fill_q);
    if (wsum >= SW'(DEPTH)) begin
      wsum = wsum - SW'(DEPTH);
    end
    waddr = wsum[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[waddr] <= write_byte_i;
    end
    if (cmd_i.pop) begin
      rdata_q <= mem[head_q];
    end
    if (cmd_i.load) begin
      code_q <= cmd_i.code;
    end
  end

  always_comb begin
    head_d   = head_q;
    fill_d   = fill_q;
    reader_d = reader_q;
    writer_d = writer_q;
    if (cmd_i.pop) begin
      head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      fill_d = fill_q - 1'b1;
    end
    if (cmd_i.push) begin
      fill_d = fill_q + 1'b1;
    end
    if (cmd_i.reader_inc) begin
      reader_d = reader_q + 1'b1;
    end
    if (cmd_i.reader_dec) begin
      reader_d = reader_q - 1'b1;
    end
    if (cmd_i.writer_set) begin
      writer_d = 1'b1;
    end
    if (cmd_i.writer_clr) begin
      writer_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      fill_q   <= '0;
      reader_q <= '0;
      writer_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      fill_q   <= fill_d;
      reader_q <= reader_d;
      writer_q <= writer_d;
    end
  end

  assign status_o.writer_holds = writer_q;
  assign status_o.empty        = (fill_q == '0);
  assign status_o.full         = (fill_q == CW'(DEPTH));
  assign status_o.no_readers   = (reader_q == '0);
  assign status_o.readers_max  = (reader_q == CW'(DEPTH));

  assign result_o.status      = code_q;
  assign result_o.read_byte   = (code_q == rwgf_pkg::StReadOk) ? rdata_q : 8'd0;
  assign result_o.readers_now = 3'(reader_q);

  // readers and the writer never hold access together
  a_lock_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(writer_q && (reader_q != '0)))
    else $error("readers and writer active together");

  // no push into a full fifo, no pop from an empty one
  a_push_pop_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && status_o.full) && !(cmd_i.pop && status_o.empty))
    else $error("fifo overflow or underflow");

  // a pop moves fill count down by one
  a_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> (fill_q == $past(fill_q) - 1'b1))
    else $error("fill count not decremented on pop");

endmodule

`default_nettype wire

// ----- hw/rtl/rwgf_ctrl.sv -----
// rwgf_ctrl: handshake state machine and operation decode for the gated fifo
// depends on rwgf_pkg; commands rwgf_datapath from its status flags
`timescale 1ns / 1ps
`default_nettype none

module rwgf_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire  [1:0]           op_i,
  input  wire                  out_stall_i,
  input  rwgf_pkg::dp_status_t dp_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output rwgf_pkg::cmd_t       cmd_o
);

  localparam logic SIdle = 1'b0;
  localparam logic SResp = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign out_valid_o = (state_q == SResp);
  assign in_stall_o  = out_valid_o && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept) state_d = SResp;
      end
      SResp: begin
        if (accept) state_d = SResp;
        else if (!out_stall_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // decode in the fixed order of checks
  always_comb begin
    cmd_o      = '0;
    cmd_o.load = accept;
    unique case (op_i)
      rwgf_pkg::OpReadStart: begin
        if (dp_i.writer_holds) cmd_o.code = rwgf_pkg::StWriterActive;
        else if (dp_i.empty) cmd_o.code = rwgf_pkg::StEmpty;
        else begin
          cmd_o.code       = rwgf_pkg::StReadOk;
          cmd_o.pop        = accept;
          cmd_o.reader_inc = accept && !dp_i.readers_max;
        end
      end
      rwgf_pkg::OpReadStop: begin
        if (dp_i.no_readers) cmd_o.code = rwgf_pkg::StNoReader;
        else if (dp_i.writer_holds) cmd_o.code = rwgf_pkg::StWriterActive;
        else begin
          cmd_o.code       = rwgf_pkg::StReadStopped;
          cmd_o.reader_dec = accept;
        end
      end
      rwgf_pkg::OpWriteStart: begin
        if (!dp_i.no_readers) cmd_o.code = rwgf_pkg::StReadersActive;
        else if (dp_i.writer_holds) cmd_o.code = rwgf_pkg::StWriterActive;
        else if (dp_i.full) cmd_o.code = rwgf_pkg::StFull;
        else begin
          cmd_o.code       = rwgf_pkg::StWriteOk;
          cmd_o.push       = accept;
          cmd_o.writer_set = accept;
        end
      end
      rwgf_pkg::OpWriteStop: begin
        if (!dp_i.writer_holds) cmd_o.code = rwgf_pkg::StNoWriter;
        else if (!dp_i.no_readers) cmd_o.code = rwgf_pkg::StReadersActive;
        else begin
          cmd_o.code       = rwgf_pkg::StWriteStopped;
          cmd_o.writer_clr = accept;
        end
      end
      default: cmd_o.code = rwgf_pkg::StNoWriter;
    endcase
  end

  // datapath state changes only happen on an accepted transaction
  a_cmd_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop || cmd_o.push || cmd_o.reader_inc || cmd_o.reader_dec ||
     cmd_o.writer_set || cmd_o.writer_clr) |-> accept)
    else $error("datapath command without accepted transaction");

endmodule

`default_nettype wire

// ----- hw/rtl/reader_writer_gated_fifo.sv -----
// reader_writer_gated_fifo: result valid in the cycle after accept;
// throughput one transaction per cycle while out_stall_i is low, set by the
// single result register; the next is taken in the cycle this result is taken
// reset: asynchronous active low; fifo empty, no readers, no writer, no result
// fifo slots are not cleared and hold unknown data until written
// depends on rwgf_pkg, rwgf_ctrl, rwgf_datapath
`timescale 1ns / 1ps
`default_nettype none

module reader_writer_gated_fifo #(
  parameter int unsigned DEPTH = rwgf_pkg::DefaultDepth
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  // request channel
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  rwgf_pkg::in_t   in_data_i,
  // result channel
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output rwgf_pkg::out_t  out_data_o
);

  // command and status between controller and datapath
  rwgf_pkg::cmd_t       cmd;
  rwgf_pkg::dp_status_t dp_status;

  // controller: owns the handshake and decides each operation's outcome
  rwgf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (in_data_i.op),
    .out_stall_i (out_stall_i),
    .dp_i        (dp_status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // datapath: fifo memory with registered read, counters and result register
  rwgf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .write_byte_i (in_data_i.write_byte),
    .status_o     (dp_status),
    .result_o     (out_data_o)
  );

  // every accepted transaction shows a result in the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted transaction produced no result");

endmodule

`default_nettype wire
